FILE: src/wprtd_pkg.sv
package wprtd_pkg;

  localparam int MAX_WAYPOINTS_DEF = 16;

  // vectoring cordic: inputs scaled by 2^30, angle in 2^-24 turn
  localparam int CORDIC_STEPS = 22;
  localparam int CORDIC_W     = 50;
  localparam int SCALE_SHIFT  = 30;
  localparam int DIFF_W       = 17;
  localparam int ANG_W        = 24;

  localparam logic [ANG_W-1:0] HALF_TURN_Z = 24'h800000;
  localparam logic [ANG_W-1:0] ROUND_HALF  = 24'd128;

  localparam logic [ANG_W-1:0] ARC_TAB [CORDIC_STEPS] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
    24'd10,      24'd5,       24'd3,      24'd1
  };

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORWARD_SPEED  = 3'd0,
    CFG_TURN_RATE      = 3'd1,
    CFG_REACH_RADIUS   = 3'd2,
    CFG_HEADING_TOL    = 3'd3,
    CFG_WAYPOINT_COUNT = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] FORWARD_SPEED_RST  = 16'd768;
  localparam logic [14:0] TURN_RATE_RST      = 15'd4096;
  localparam logic [14:0] REACH_RADIUS_RST   = 15'd128;
  localparam logic [29:0] REACH_SQ_RST       = 30'd16384;
  localparam logic [14:0] HEADING_TOL_RST    = 15'd2048;
  localparam logic [4:0]  WAYPOINT_COUNT_RST = 5'd5;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        heading;
    logic [3:0]         wp_slot;
    logic signed [15:0] wp_x;
    logic signed [15:0] wp_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] angular_cmd;
    logic [15:0]        linear_cmd;
    logic               target_reached;
    logic [3:0]         next_target;
  } out_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic [ANG_W-1:0]           z;
  } vec_t;

  typedef struct packed {
    logic        zero_vec;
    logic [15:0] heading;
    logic        reached;
    logic [3:0]  next_target;
  } meta_t;

  typedef struct packed {
    logic [15:0] forward_speed;
    logic [14:0] turn_rate;
    logic [14:0] heading_tolerance;
  } drive_cfg_t;

  // default route, Q8.8 metres
  function automatic logic signed [15:0] route_x(input int i);
    logic signed [15:0] v;
    case (i)
      0:       v = 16'sd2048;
      1:       v = -16'sd1280;
      2:       v = -16'sd2304;
      3:       v = 16'sd1536;
      4:       v = 16'sd2816;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] route_y(input int i);
    logic signed [15:0] v;
    case (i)
      0:       v = 16'sd1792;
      1:       v = 16'sd2048;
      2:       v = -16'sd1024;
      3:       v = -16'sd2304;
      4:       v = -16'sd256;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/wprtd_front.sv
module wprtd_front #(
  parameter int MAX_WAYPOINTS = wprtd_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pose_take,
  input  logic              write_take,
  input  wprtd_pkg::in_t    item,
  input  logic [4:0]        waypoint_count,
  input  logic [29:0]       reach_sq,
  output wprtd_pkg::vec_t   vec,
  output wprtd_pkg::meta_t  meta
);
  import wprtd_pkg::*;

  localparam int IW  = $clog2(MAX_WAYPOINTS);
  localparam int CW  = $clog2(MAX_WAYPOINTS + 1);
  localparam int PAD = CORDIC_W - DIFF_W - SCALE_SHIFT;

  logic signed [15:0] tab_x [MAX_WAYPOINTS];
  logic signed [15:0] tab_y [MAX_WAYPOINTS];
  logic [IW-1:0]      target_index;

  logic [CW-1:0]      count_eff;
  logic [CW-1:0]      idx_inc;
  logic [IW-1:0]      idx_cur;
  logic [IW-1:0]      idx_adv;
  logic [IW-1:0]      target_index_next;
  logic signed [15:0] wx;
  logic signed [15:0] wy;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx_r;
  logic signed [DIFF_W-1:0] dy_r;
  logic signed [33:0] sq_x;
  logic signed [33:0] sq_y;
  logic [34:0]        dist_sq;
  logic               reached;
  logic               flip;
  logic               slot_ok;
  logic [IW-1:0]      slot_idx;

  always_comb begin
    // route length clamped into 1..MAX_WAYPOINTS
    if (waypoint_count == '0) begin
      count_eff = CW'(1);
    end else if (32'(waypoint_count) > 32'(MAX_WAYPOINTS)) begin
      count_eff = CW'(MAX_WAYPOINTS);
    end else begin
      count_eff = CW'(waypoint_count);
    end

    // stale index falls back to the first waypoint
    idx_cur = (CW'(target_index) >= count_eff) ? '0 : target_index;
    idx_inc = CW'(idx_cur) + CW'(1);
    idx_adv = (idx_inc >= count_eff) ? '0 : IW'(idx_inc);

    wx = tab_x[idx_cur];
    wy = tab_y[idx_cur];
    dx = {wx[15], wx} - {item.pos_x[15], item.pos_x};
    dy = {wy[15], wy} - {item.pos_y[15], item.pos_y};

    sq_x    = 34'(dx) * 34'(dx);
    sq_y    = 34'(dy) * 34'(dy);
    dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    reached = dist_sq < {5'b0, reach_sq};

    target_index_next = reached ? idx_adv : idx_cur;

    // left half-plane: pre-rotate by a half turn
    flip = dx[DIFF_W-1];
    dx_r = flip ? -dx : dx;
    dy_r = flip ? -dy : dy;

    vec.x = {{PAD{dx_r[DIFF_W-1]}}, dx_r, {SCALE_SHIFT{1'b0}}};
    vec.y = {{PAD{dy_r[DIFF_W-1]}}, dy_r, {SCALE_SHIFT{1'b0}}};
    vec.z = flip ? HALF_TURN_Z : '0;

    meta.zero_vec    = (dx == '0) && (dy == '0);
    meta.heading     = item.heading;
    meta.reached     = reached;
    meta.next_target = 4'(target_index_next);

    slot_ok  = 32'(item.wp_slot) < 32'(MAX_WAYPOINTS);
    slot_idx = IW'(item.wp_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WAYPOINTS; i++) begin
        tab_x[i] <= route_x(i);
        tab_y[i] <= route_y(i);
      end
      target_index <= '0;
    end else begin
      if (write_take && slot_ok) begin
        tab_x[slot_idx] <= item.wp_x;
        tab_y[slot_idx] <= item.wp_y;
      end
      if (pose_take) begin
        target_index <= target_index_next;
      end
    end
  end

endmodule

FILE: src/wprtd_cordic_stage.sv
module wprtd_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  wprtd_pkg::vec_t   d,
  input  wprtd_pkg::meta_t  dm,
  output wprtd_pkg::vec_t   q,
  output wprtd_pkg::meta_t  qm
);
  import wprtd_pkg::*;

  logic signed [CORDIC_W-1:0] xi;
  logic signed [CORDIC_W-1:0] yi;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  vec_t                       nxt;

  always_comb begin
    xi = d.x;
    yi = d.y;
    // arithmetic shift rounds towards minus infinity
    xs = xi >>> STEP;
    ys = yi >>> STEP;
    if (!yi[CORDIC_W-1]) begin
      nxt.x = xi + ys;
      nxt.y = yi - xs;
      nxt.z = d.z + ARC_TAB[STEP];
    end else begin
      nxt.x = xi - ys;
      nxt.y = yi + xs;
      nxt.z = d.z - ARC_TAB[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q  <= nxt;
      qm <= dm;
    end
  end

endmodule

FILE: src/wprtd_decide.sv
module wprtd_decide (
  input  wprtd_pkg::vec_t       v,
  input  wprtd_pkg::meta_t      m,
  input  wprtd_pkg::drive_cfg_t cfg,
  output wprtd_pkg::out_t       res
);
  import wprtd_pkg::*;

  logic [ANG_W-1:0] z_rnd;
  logic [15:0]      bearing;
  logic [15:0]      err;
  logic [15:0]      mag;
  logic [15:0]      rate;

  always_comb begin
    z_rnd   = v.z + ROUND_HALF;
    bearing = m.zero_vec ? '0 : z_rnd[ANG_W-1:ANG_W-16];
    // wraps to [-half turn, half turn)
    err     = bearing - m.heading;
    mag     = err[15] ? (~err + 16'd1) : err;
    rate    = {1'b0, cfg.turn_rate};

    if (mag > {1'b0, cfg.heading_tolerance}) begin
      res.angular_cmd = err[15] ? -rate : rate;
      res.linear_cmd  = '0;
    end else begin
      res.angular_cmd = '0;
      res.linear_cmd  = cfg.forward_speed;
    end
    res.target_reached = m.reached;
    res.next_target    = m.next_target;
  end

endmodule

FILE: src/waypoint_rotate_then_drive_unit.sv
// a pose sample passes the input register, the cordic stages and the output register
// throughput: one transaction per cycle while out_stall is low, set by a
// 22-stage cordic pipeline with a combinational reach test and target update in front
// of it; table writes update the waypoint table when taken and give no result
// reset: pipeline empties, config registers and target index return to defaults,
// waypoint table reloads the default five-point route
module waypoint_rotate_then_drive_unit #(
  parameter int MAX_WAYPOINTS = wprtd_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wprtd_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wprtd_pkg::out_t                     out_data,
  input  logic                                cfg_write,
  input  logic [wprtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wprtd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wprtd_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic [15:0] forward_speed;
  logic [14:0] turn_rate;
  logic [29:0] reach_sq;
  logic [14:0] heading_tolerance;
  logic [4:0]  waypoint_count;

  logic        in_take;
  logic        pose_take;
  logic        write_take;
  logic        out_ready;

  vec_t        front_vec;
  meta_t       front_meta;
  vec_t        stg_vec  [N+1];
  meta_t       stg_meta [N+1];
  logic [N:0]  stg_valid;
  logic [N:0]  stg_ready;
  drive_cfg_t  drive_cfg;
  out_t        result;

  assign in_take    = in_valid && !in_stall;
  assign pose_take  = in_take && !in_data.cmd;
  assign write_take = in_take && in_data.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed     <= FORWARD_SPEED_RST;
      turn_rate         <= TURN_RATE_RST;
      reach_sq          <= REACH_SQ_RST;
      heading_tolerance <= HEADING_TOL_RST;
      waypoint_count    <= WAYPOINT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORWARD_SPEED:  forward_speed <= cfg_data;
        CFG_TURN_RATE:      turn_rate <= cfg_data[14:0];
        CFG_REACH_RADIUS: begin
          reach_sq <= 30'(cfg_data[14:0]) * 30'(cfg_data[14:0]);
        end
        CFG_HEADING_TOL:    heading_tolerance <= cfg_data[14:0];
        CFG_WAYPOINT_COUNT: waypoint_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign drive_cfg.forward_speed     = forward_speed;
  assign drive_cfg.turn_rate         = turn_rate;
  assign drive_cfg.heading_tolerance = heading_tolerance;

  wprtd_front #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .pose_take      (pose_take),
    .write_take     (write_take),
    .item           (in_data),
    .waypoint_count (waypoint_count),
    .reach_sq       (reach_sq),
    .vec            (front_vec),
    .meta           (front_meta)
  );

  // elastic pipeline: a stage loads whenever it is empty or its successor moves
  assign out_ready    = !out_valid || !out_stall;
  assign stg_ready[N] = !stg_valid[N] || out_ready;

  for (genvar k = 0; k < N; k++) begin : g_ready
    assign stg_ready[k] = !stg_valid[k] || stg_ready[k+1];
  end

  assign in_stall = !stg_ready[0];

  always_ff @(posedge clk) begin
    if (stg_ready[0]) begin
      stg_vec[0]  <= front_vec;
      stg_meta[0] <= front_meta;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    wprtd_cordic_stage #(
      .STEP(k - 1)
    ) u_stage (
      .clk (clk),
      .en  (stg_ready[k]),
      .d   (stg_vec[k-1]),
      .dm  (stg_meta[k-1]),
      .q   (stg_vec[k]),
      .qm  (stg_meta[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stg_ready[0]) begin
        stg_valid[0] <= pose_take;
      end
      for (int k = 1; k <= N; k++) begin
        if (stg_ready[k]) begin
          stg_valid[k] <= stg_valid[k-1];
        end
      end
      if (out_ready) begin
        out_valid <= stg_valid[N];
      end
    end
  end

  wprtd_decide u_decide (
    .v   (stg_vec[N]),
    .m   (stg_meta[N]),
    .cfg (drive_cfg),
    .res (result)
  );

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_data <= result;
    end
  end

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wprtd_pkg::*;

  localparam int         NUM_SLOTS    = MAX_WAYPOINTS_DEF;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         TAIL_CYCLES  = 40;
  localparam int         PHASES       = 14;
  localparam int         PHASE_ITEMS  = 125;
  localparam longint     VEC_SCALE    = 64'sd1073741824;
  localparam logic       CMD_POSE     = 1'b0;
  localparam logic       CMD_WP_WRITE = 1'b1;
  localparam logic [2:0] CFG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

  // arc of each cordic step in 2^-24 turn
  localparam logic [23:0] TURN_ARCS [22] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
    24'd41718,   24'd20860,   24'd10430,  24'd5215,   24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81,     24'd41,     24'd20,
    24'd10,      24'd5,       24'd3,      24'd1
  };

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    in_t         item;
    bit          typed;
    out_t        want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // local copy of the route and drive settings
  logic signed [15:0] way_x [NUM_SLOTS];
  logic signed [15:0] way_y [NUM_SLOTS];
  int                 tgt_idx;
  logic [15:0]        fwd_speed;
  logic [14:0]        turn_mag;
  logic [14:0]        reach_rad;
  logic [14:0]        head_tol;
  logic [4:0]         route_count;

  out_t pending_cmds [$];
  out_t popped;
  int   mismatches = 0;
  bit   tx_idles = 1'b1;
  bit   rx_idles = 1'b1;

  waypoint_rotate_then_drive_unit dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int route_len();
    if (route_count == 0) return 1;
    if (int'(route_count) > NUM_SLOTS) return NUM_SLOTS;
    return int'(route_count);
  endfunction

  function automatic logic [15:0] bearing_of(input longint dx, input longint dy);
    longint      vx, vy, sx, sy;
    logic [23:0] ang, rounded;
    int          i;
    if (dx == 0 && dy == 0) return '0;
    vx = dx * VEC_SCALE;
    vy = dy * VEC_SCALE;
    ang = '0;
    if (vx < 0) begin
      vx = -vx;
      vy = -vy;
      ang = 24'h800000;
    end
    for (i = 0; i < 22; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + sy;
        vy = vy - sx;
        ang = ang + TURN_ARCS[i];
      end else begin
        vx = vx - sy;
        vy = vy + sx;
        ang = ang - TURN_ARCS[i];
      end
    end
    rounded = ang + 24'd128;
    return rounded[23:8];
  endfunction

  // advances the route state for one transaction; returns 1 when a command is due
  function automatic bit route_step(input in_t it, output out_t res);
    int          cnt, err, mag, ang;
    longint      dx, dy, d2, r2;
    logic [15:0] brg, err_u, lin;
    bit          reached;
    res = '0;
    if (it.cmd == CMD_WP_WRITE) begin
      way_x[it.wp_slot] = it.wp_x;
      way_y[it.wp_slot] = it.wp_y;
      return 1'b0;
    end
    cnt = route_len();
    if (tgt_idx >= cnt) tgt_idx = 0;
    dx = longint'(way_x[tgt_idx]) - longint'($signed(it.pos_x));
    dy = longint'(way_y[tgt_idx]) - longint'($signed(it.pos_y));
    brg = bearing_of(dx, dy);
    err_u = brg - it.heading;
    err = int'($signed(err_u));
    mag = err < 0 ? -err : err;
    ang = 0;
    lin = '0;
    if (mag > int'(head_tol)) ang = err > 0 ? int'(turn_mag) : -int'(turn_mag);
    else lin = fwd_speed;
    d2 = dx * dx + dy * dy;
    r2 = longint'(reach_rad) * longint'(reach_rad);
    reached = d2 < r2;
    if (reached) begin
      tgt_idx++;
      if (tgt_idx >= cnt) tgt_idx = 0;
    end
    res.angular_cmd = 16'(ang);
    res.linear_cmd = lin;
    res.target_reached = reached;
    res.next_target = 4'(tgt_idx);
    return 1'b1;
  endfunction

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic in_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic stim_row_t pose_row(input int x, input int y, input int h);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item = random_item();
    r.item.cmd = CMD_POSE;
    r.item.pos_x = 16'(x);
    r.item.pos_y = 16'(y);
    r.item.heading = 16'(h);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t expect_row(input int x, input int y, input int h,
                                           input int ang, input int lin,
                                           input bit reached, input int nxt);
    stim_row_t r;
    r = pose_row(x, y, h);
    r.typed = 1'b1;
    r.want.angular_cmd = 16'(ang);
    r.want.linear_cmd = 16'(lin);
    r.want.target_reached = reached;
    r.want.next_target = 4'(nxt);
    return r;
  endfunction

  function automatic stim_row_t wp_row(input int slot, input int x, input int y);
    stim_row_t r;
    r = pose_row(0, 0, 0);
    r.item = random_item();
    r.item.cmd = CMD_WP_WRITE;
    r.item.wp_slot = 4'(slot);
    r.item.wp_x = 16'(x);
    r.item.wp_y = 16'(y);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [15:0] val);
    stim_row_t r;
    r = pose_row(0, 0, 0);
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic send_item(input in_t it, input bit typed, input out_t want);
    int   gap;
    bit   has;
    out_t res;
    gap = tx_idles ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    has = route_step(it, res);
    if (has) pending_cmds.push_back(typed ? want : res);
  endtask

  // let every pose in flight come out before touching the registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [2:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FORWARD_SPEED:  fwd_speed = val;
      CFG_TURN_RATE:      turn_mag = val[14:0];
      CFG_REACH_RADIUS:   reach_rad = val[14:0];
      CFG_HEADING_TOL:    head_tol = val[14:0];
      CFG_WAYPOINT_COUNT: route_count = val[4:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", out_data));
      end else begin
        popped = pending_cmds.pop_front();
        if (out_data.angular_cmd !== popped.angular_cmd)
          report_mismatch($sformatf("angular_cmd got %0d want %0d",
                                    out_data.angular_cmd, popped.angular_cmd));
        if (out_data.linear_cmd !== popped.linear_cmd)
          report_mismatch($sformatf("linear_cmd got %0d want %0d",
                                    out_data.linear_cmd, popped.linear_cmd));
        if (out_data.target_reached !== popped.target_reached)
          report_mismatch($sformatf("target_reached got %0b want %0b",
                                    out_data.target_reached, popped.target_reached));
        if (out_data.next_target !== popped.next_target)
          report_mismatch($sformatf("next_target got %0d want %0d",
                                    out_data.next_target, popped.next_target));
      end
    end
  end

  // receiving side: random hold-off before each result while rx_idles is set
  initial begin : sink
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = rx_idles ? $urandom_range(0, 16) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [$];
    stim_row_t   row;
    in_t         it;
    int          ph, n, r, t, spread, ox, oy, jit;
    longint      dx, dy;
    logic [15:0] brg, fv, tv, rv, hv, cv;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      way_x[i] = '0;
      way_y[i] = '0;
    end
    way_x[0] = 16'sd2048;  way_y[0] = 16'sd1792;
    way_x[1] = -16'sd1280; way_y[1] = 16'sd2048;
    way_x[2] = -16'sd2304; way_y[2] = -16'sd1024;
    way_x[3] = 16'sd1536;  way_y[3] = -16'sd2304;
    way_x[4] = 16'sd2816;  way_y[4] = -16'sd256;
    tgt_idx = 0;
    fwd_speed = 16'd768;
    turn_mag = 15'd4096;
    reach_rad = 15'd128;
    head_tol = 15'd2048;
    route_count = 5'd5;

    // on the target, then on the target facing away by exactly half a turn
    directed_rows.push_back(expect_row(2048, 1792, 0, 0, 768, 1'b1, 1));
    directed_rows.push_back(expect_row(-1280, 2048, 32768, -4096, 0, 1'b1, 2));
    directed_rows.push_back(pose_row(-32768, -32768, 0));
    directed_rows.push_back(pose_row(32767, 32767, 65535));
    directed_rows.push_back(pose_row(-32768, 32767, 16384));
    directed_rows.push_back(wp_row(15, 32767, -32768));
    directed_rows.push_back(wp_row(0, -32768, 32767));
    // shrinking the route below the current target index
    directed_rows.push_back(cfg_row(CFG_WAYPOINT_COUNT, 16'd2));
    directed_rows.push_back(expect_row(-32768, 32767, 0, 0, 768, 1'b1, 1));
    directed_rows.push_back(expect_row(-1280, 2048, 0, 0, 768, 1'b1, 0));
    // zero-length route behaves as a single waypoint
    directed_rows.push_back(cfg_row(CFG_WAYPOINT_COUNT, 16'd0));
    directed_rows.push_back(expect_row(-32768, 32767, 0, 0, 768, 1'b1, 0));
    directed_rows.push_back(cfg_row(CFG_WAYPOINT_COUNT, 16'd31));
    directed_rows.push_back(cfg_row(CFG_FORWARD_SPEED, 16'hFFFF));
    directed_rows.push_back(cfg_row(CFG_TURN_RATE, 16'hFFFF));
    directed_rows.push_back(cfg_row(CFG_HEADING_TOL, 16'h0000));
    directed_rows.push_back(cfg_row(CFG_REACH_RADIUS, 16'hFFFF));
    directed_rows.push_back(pose_row(32767, 32767, 0));
    directed_rows.push_back(expect_row(-32768, 32767, 0, 0, 65535, 1'b1, 1));
    // unmapped register indexes must leave everything alone
    directed_rows.push_back(cfg_row(CFG_UNMAPPED_LO, 16'h0000));
    directed_rows.push_back(cfg_row(CFG_UNMAPPED_HI, 16'hFFFF));
    directed_rows.push_back(expect_row(-1280, 2048, 0, 0, 65535, 1'b1, 2));
    directed_rows.push_back(cfg_row(CFG_HEADING_TOL, 16'hFFFF));
    directed_rows.push_back(expect_row(-2304, -1024, 32768, -32767, 0, 1'b1, 3));
    directed_rows.push_back(pose_row(1024, -2304, 32768));
    directed_rows.push_back(pose_row(0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        settle();
        cfg_set(row.reg_idx, row.reg_val);
      end else begin
        send_item(row.item, row.typed, row.want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_idles = (ph % 3) != 2;
      rx_idles = (ph % 4) != 3;
      if (ph == 0) begin
        fv = '0; tv = '0; rv = '0; hv = '0; cv = 16'd1;
      end else if (ph == 1) begin
        fv = '1; tv = '1; rv = '1; hv = '1; cv = '1;
      end else begin
        fv = 16'($urandom);
        tv = 16'($urandom);
        rv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 1024));
        hv = $urandom_range(0, 1) ? 16'($urandom_range(0, 8192)) : 16'($urandom);
        cv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16));
      end
      cfg_set(CFG_FORWARD_SPEED, fv);
      cfg_set(CFG_TURN_RATE, tv);
      cfg_set(CFG_REACH_RADIUS, rv);
      cfg_set(CFG_HEADING_TOL, hv);
      cfg_set(CFG_WAYPOINT_COUNT, cv);

      for (n = 0; n < PHASE_ITEMS; n++) begin
        it = random_item();
        r = $urandom_range(0, 99);
        if (r < 12) begin
          it.cmd = CMD_WP_WRITE;
          if ($urandom_range(0, 9) < 7) begin
            it.wp_x = clamp16(int'($urandom_range(0, 10240)) - 5120);
            it.wp_y = clamp16(int'($urandom_range(0, 10240)) - 5120);
          end
        end else if (r < 22) begin
          it.cmd = CMD_POSE;
        end else begin
          // pose close to the current target so the route keeps advancing
          it.cmd = CMD_POSE;
          t = (tgt_idx >= route_len()) ? 0 : tgt_idx;
          spread = int'(reach_rad) * 2 + 8;
          if (r < 27) begin
            ox = 0;
            oy = 0;
          end else begin
            ox = int'($urandom_range(0, 2 * spread)) - spread;
            oy = int'($urandom_range(0, 2 * spread)) - spread;
          end
          it.pos_x = clamp16(int'(way_x[t]) + ox);
          it.pos_y = clamp16(int'(way_y[t]) + oy);
          dx = longint'(way_x[t]) - longint'($signed(it.pos_x));
          dy = longint'(way_y[t]) - longint'($signed(it.pos_y));
          if ($urandom_range(0, 9) < 6) begin
            brg = bearing_of(dx, dy);
            jit = int'($urandom_range(0, 2 * (int'(head_tol) + 64))) - int'(head_tol) - 64;
            it.heading = 16'(int'(brg) + jit);
          end
        end
        send_item(it, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
src/wprtd_pkg.sv
src/wprtd_front.sv
src/wprtd_cordic_stage.sv
src/wprtd_decide.sv
src/waypoint_rotate_then_drive_unit.sv
dv/testbench.sv
